### rtl/utmp_pkg.sv
// Shared constants and types for the UTF-8 MP3 path validator.
// No dependencies; imported by every module of the block.
package utmp_pkg;

  localparam int MAX_PATH_BYTES = 255;
  // Byte counter holds up to MAX_PATH_BYTES + 1.
  localparam int CNT_W = $clog2(MAX_PATH_BYTES + 2);
  localparam int LEN_W = 9;

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DEL       = 8'h7F;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_M_LOW     = 8'h6D;
  localparam logic [7:0] CH_M_UP      = 8'h4D;
  localparam logic [7:0] CH_P_LOW     = 8'h70;
  localparam logic [7:0] CH_P_UP      = 8'h50;
  localparam logic [7:0] CH_THREE     = 8'h33;

  localparam logic [7:0] U8_ASCII_MAX = 8'h7F;
  localparam logic [7:0] U8_LEAD2_MIN = 8'hC2;
  localparam logic [7:0] U8_LEAD2_MAX = 8'hDF;
  localparam logic [7:0] U8_LEAD3_MIN = 8'hE0;
  localparam logic [7:0] U8_LEAD3_MAX = 8'hEF;
  localparam logic [7:0] U8_LEAD4_MIN = 8'hF0;
  localparam logic [7:0] U8_LEAD4_MAX = 8'hF4;
  localparam logic [7:0] U8_E0        = 8'hE0;
  localparam logic [7:0] U8_ED        = 8'hED;
  localparam logic [7:0] U8_MIN_A0    = 8'hA0;
  localparam logic [7:0] U8_MAX_9F    = 8'h9F;
  localparam logic [7:0] U8_MIN_90    = 8'h90;
  localparam logic [7:0] U8_MAX_8F    = 8'h8F;

  typedef enum logic [2:0] {
    RULE_NONE   = 3'd0,
    RULE_MIN_A0 = 3'd1,
    RULE_MAX_9F = 3'd2,
    RULE_MIN_90 = 3'd3,
    RULE_MAX_8F = 3'd4
  } rule_t;

  typedef struct packed {
    logic             ok;
    logic [LEN_W-1:0] length;
  } result_t;

endpackage

### rtl/utmp_in_reg.sv
// Input register stage of the path validator: holds one byte request.
// Depends on utmp_pkg.
module utmp_in_reg
  import utmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] path_byte,
  input  logic       last_byte,
  input  logic       advance,
  output logic       s1_valid,
  output logic [7:0] s1_byte,
  output logic       s1_last
);

  // Take a new request when empty or when the held one moves on.
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= path_byte;
      s1_last <= last_byte;
    end
  end

endmodule

### rtl/utmp_scan.sv
// Running path and UTF-8 state of the validator; computes the verdict on
// the last byte of a path. Depends on utmp_pkg.
module utmp_scan
  import utmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s1_valid,
  input  logic [7:0] s1_byte,
  input  logic       s1_last,
  input  logic       out_free,
  output logic       advance,
  output logic       res_load,
  output result_t    res
);

  typedef struct packed {
    logic [CNT_W-1:0] bytes_seen;
    logic [1:0]       cont_left;
    rule_t            rule;
    logic             broken;
    logic [1:0]       seg_size;
    logic             seg_dots;
    logic [23:0]      prev;
  } scan_state_t;

  localparam scan_state_t STATE_CLEAR = '{
    bytes_seen: '0, cont_left: 2'd0, rule: RULE_NONE, broken: 1'b0,
    seg_size: 2'd0, seg_dots: 1'b1, prev: 24'd0};

  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_PATH_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PATH_BYTES);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(4);

  scan_state_t      st;
  scan_state_t      st_next;
  scan_state_t      upd;
  logic [CNT_W-1:0] count;
  logic             seg_bad_upd;
  logic             bad_cont;
  logic             ok;

  // A non-final byte never produces a result, so it always moves on.
  assign advance  = s1_valid && (!s1_last || out_free);
  assign res_load = advance && s1_last;

  always_comb begin
    upd      = st;
    bad_cont = 1'b0;

    // Path shape rules.
    if (st.bytes_seen == '0) begin
      if (s1_byte != CH_SLASH) upd.broken = 1'b1;
    end else begin
      if (s1_byte < CH_SPACE || s1_byte == CH_DEL || s1_byte == CH_BACKSLASH) begin
        upd.broken = 1'b1;
      end
      if (s1_byte == CH_SLASH) begin
        if (st.seg_size == 2'd0 || (st.seg_dots && st.seg_size <= 2'd2)) begin
          upd.broken = 1'b1;
        end
        upd.seg_size = 2'd0;
        upd.seg_dots = 1'b1;
      end else begin
        if (st.seg_size != 2'd3) upd.seg_size = st.seg_size + 2'd1;
        if (s1_byte != CH_DOT) upd.seg_dots = 1'b0;
      end
    end

    // Strict UTF-8 decoding.
    upd.rule = RULE_NONE;
    if (st.cont_left != 2'd0) begin
      bad_cont = (s1_byte[7:6] != 2'b10) ||
                 (st.rule == RULE_MIN_A0 && s1_byte < U8_MIN_A0) ||
                 (st.rule == RULE_MAX_9F && s1_byte > U8_MAX_9F) ||
                 (st.rule == RULE_MIN_90 && s1_byte < U8_MIN_90) ||
                 (st.rule == RULE_MAX_8F && s1_byte > U8_MAX_8F);
      if (bad_cont) begin
        upd.broken    = 1'b1;
        upd.cont_left = 2'd0;
      end else begin
        upd.cont_left = st.cont_left - 2'd1;
      end
    end else if (s1_byte <= U8_ASCII_MAX) begin
      upd.cont_left = 2'd0;
    end else if (s1_byte >= U8_LEAD2_MIN && s1_byte <= U8_LEAD2_MAX) begin
      upd.cont_left = 2'd1;
    end else if (s1_byte >= U8_LEAD3_MIN && s1_byte <= U8_LEAD3_MAX) begin
      upd.cont_left = 2'd2;
      if (s1_byte == U8_E0) upd.rule = RULE_MIN_A0;
      if (s1_byte == U8_ED) upd.rule = RULE_MAX_9F;
    end else if (s1_byte >= U8_LEAD4_MIN && s1_byte <= U8_LEAD4_MAX) begin
      upd.cont_left = 2'd3;
      if (s1_byte == U8_LEAD4_MIN) upd.rule = RULE_MIN_90;
      if (s1_byte == U8_LEAD4_MAX) upd.rule = RULE_MAX_8F;
    end else begin
      upd.broken = 1'b1;
    end

    // Saturating byte count.
    count = (st.bytes_seen == CNT_SAT) ? CNT_SAT : st.bytes_seen + CNT_W'(1);
    upd.bytes_seen = count;
    upd.prev       = {st.prev[15:0], s1_byte};

    seg_bad_upd = (upd.seg_size == 2'd0) || (upd.seg_dots && upd.seg_size <= 2'd2);

    ok = !upd.broken && count > CNT_MIN && count <= CNT_MAX &&
         upd.cont_left == 2'd0 && !seg_bad_upd &&
         st.prev[23:16] == CH_DOT &&
         (st.prev[15:8] == CH_M_LOW || st.prev[15:8] == CH_M_UP) &&
         (st.prev[7:0] == CH_P_LOW || st.prev[7:0] == CH_P_UP) &&
         s1_byte == CH_THREE;

    res.ok     = ok;
    res.length = LEN_W'(count);

    // Clear everything after the last byte of a path.
    st_next = s1_last ? STATE_CLEAR : upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_CLEAR;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

### rtl/utmp_out_reg.sv
// Result register of the path validator: holds one verdict until taken.
// Depends on utmp_pkg.
module utmp_out_reg
  import utmp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             res_load,
  input  result_t          res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             path_ok,
  output logic [LEN_W-1:0] path_length
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      path_ok     <= res.ok;
      path_length <= res.length;
    end
  end

endmodule

### rtl/utf8_mp3_path_validator.sv
// Top level of the UTF-8 MP3 path validator.
// Depends on utmp_pkg, utmp_in_reg, utmp_scan and utmp_out_reg.
//
// Usage:
//   A path enters one byte per request on the input channel (in_valid /
//   in_ready, path_byte, last_byte); last_byte marks the final byte.
//   Each path gives exactly one result request on the output channel
//   (out_valid / out_ready, path_ok, path_length), issued for its last
//   byte; other bytes give none.
//   A last byte passes through one input register, then one result
//   register, before its result shows.
//   Throughput: one byte per cycle outside a stall; the running state is
//   updated by a single short logic pass between input and result registers.
//   Stall: while a result waits, non-final bytes keep flowing; a further
//   last byte holds in the input register, with in_ready low, until the
//   waiting result is taken.
//   Reset (rst, synchronous): drop any held request and clear the path
//   state; no clearing pass is needed.
module utf8_mp3_path_validator
  import utmp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       path_byte,
  input  logic             last_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             path_ok,
  output logic [LEN_W-1:0] path_length
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       advance;
  logic       res_load;
  logic       out_free;
  result_t    res;

  // Hold the incoming byte request.
  utmp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .path_byte (path_byte),
    .last_byte (last_byte),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte),
    .s1_last   (s1_last)
  );

  // Advance the running path state and form the verdict.
  utmp_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte),
    .s1_last  (s1_last),
    .out_free (out_free),
    .advance  (advance),
    .res_load (res_load),
    .res      (res)
  );

  // Hold the verdict until the receiver takes it.
  utmp_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .res_load    (res_load),
    .res         (res),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .path_ok     (path_ok),
    .path_length (path_length)
  );

endmodule

### rtl/utmp_checker.sv
// Port-level checks for the path validator, bound to the top level.
// Depends on utmp_pkg and utf8_mp3_path_validator.
module utmp_checker
  import utmp_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [7:0]       path_byte,
  input logic             last_byte,
  input logic             out_valid,
  input logic             out_ready,
  input logic             path_ok,
  input logic [LEN_W-1:0] path_length
);

  // A waiting byte request keeps its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(path_byte) && $stable(last_byte))
    else $error("waiting byte request changed");

  // A stalled result keeps its request and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(path_ok) && $stable(path_length))
    else $error("stalled result changed");

  // No result comes out right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A result counts at least its own last byte.
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> path_length != '0)
    else $error("result with zero length");

  // An accepted path is longer than four bytes.
  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && path_ok |-> path_length > LEN_W'(4))
    else $error("short path accepted");

endmodule

bind utf8_mp3_path_validator utmp_checker u_utmp_checker (.*);
